FILE: hw/rtl/set_assoc_cache_tree_plru_top_defines.svh
// assertion macros for the tree plru cache block
// used by set_assoc_cache_tree_plru_top, expects clk and rst_n in scope
`ifndef SET_ASSOC_CACHE_TREE_PLRU_TOP_DEFINES_SVH
`define SET_ASSOC_CACHE_TREE_PLRU_TOP_DEFINES_SVH

// same-cycle implication
`define SACPLRU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SACPLRU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/sacplru_pkg.sv
// types, constants and tree plru functions for the cache block
// no dependencies
package sacplru_pkg;

  localparam int ADDR_W      = 64;
  localparam int OFFSET_BITS = 6;
  localparam int SETS        = 256;
  localparam int WAYS        = 8;
  localparam int SET_W       = $clog2(SETS);
  localparam int WAY_W       = $clog2(WAYS);
  localparam int TAG_W       = ADDR_W - OFFSET_BITS - SET_W;
  localparam int TREE_W      = WAYS - 1;
  localparam int CNT_W       = 32;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [SET_W-1:0]  set_idx_t;
  typedef logic [WAY_W-1:0]  way_t;
  typedef logic [TAG_W-1:0]  tag_t;
  typedef logic [TREE_W-1:0] tree_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    set_idx_t set_idx;
    tag_t     tag;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } q_head_t;

  typedef struct packed {
    logic busy;
  } back_stat_t;

  typedef struct packed {
    tree_t                     tree;
    logic [WAYS-1:0]           valid;
    logic [WAYS-1:0][TAG_W-1:0] tag;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  // walk from the root following the tree bits
  function automatic way_t tree_victim(tree_t tree);
    int node;
    int dir;
    int l;
    node = 0;
    for (l = 0; l < WAY_W; l++) begin
      dir  = int'(tree[TREE_W-1-node]);
      node = 2 * node + 1 + dir;
    end
    return way_t'(node - (WAYS - 1));
  endfunction

  // point every node on the way's path to the other subtree
  function automatic tree_t tree_touch(tree_t tree, way_t way);
    tree_t t;
    int    node;
    int    dir;
    int    l;
    t    = tree;
    node = 0;
    for (l = 0; l < WAY_W; l++) begin
      dir = int'(way[WAY_W-1-l]);
      t[TREE_W-1-node] = (dir == 0);
      node = 2 * node + 1 + dir;
    end
    return t;
  endfunction

endpackage

FILE: hw/rtl/sacplru_if.sv
// request and result channel interfaces for the cache block
// depends on sacplru_pkg
interface sacplru_in_if;
  import sacplru_pkg::*;

  logic  valid;
  logic  ready;
  addr_t access_address;

  modport source (output valid, output access_address, input ready);
  modport sink (input valid, input access_address, output ready);
endinterface

interface sacplru_out_if;
  import sacplru_pkg::*;

  logic valid;
  logic ready;
  logic is_miss;
  way_t way_used;
  cnt_t hits_so_far;
  cnt_t misses_so_far;

  modport source (output valid, output is_miss, output way_used, output hits_so_far,
                  output misses_so_far, input ready);
  modport sink (input valid, input is_miss, input way_used, input hits_so_far,
                input misses_so_far, output ready);
endinterface

FILE: hw/rtl/sacplru_ram.sv
// generic single write port ram with registered read
// no dependencies
module sacplru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/sacplru_front.sv
// front end: accepts requests, splits set index and tag, small queue
// depends on sacplru_pkg and sacplru_if
module sacplru_front (
  input  logic                 clk,
  input  logic                 rst_n,
  sacplru_in_if.sink           in_chan,
  output sacplru_pkg::q_head_t q_head,
  input  logic                 q_pop
);
  import sacplru_pkg::*;

  req_t              q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic [QPTR_W:0]   count_nxt;
  logic              push;
  req_t              req_in;

  always_comb begin
    req_in.set_idx = in_chan.access_address[OFFSET_BITS +: SET_W];
    req_in.tag     = in_chan.access_address[ADDR_W-1 -: TAG_W];
  end

  assign in_chan.ready = (count_r != (QPTR_W + 1)'(QDEPTH));
  assign push          = in_chan.valid && in_chan.ready;

  assign q_head.valid = (count_r != '0);
  assign q_head.req   = q_mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + (QPTR_W + 1)'(1);
    end else if (!push && q_pop) begin
      count_nxt = count_r - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= req_in;
    end
  end

endmodule

FILE: hw/rtl/sacplru_back.sv
// back end: set row lookup, tag compare, victim fill, tree update, counters
// depends on sacplru_pkg, sacplru_if and sacplru_ram
module sacplru_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sacplru_pkg::q_head_t    q_head,
  output logic                    q_pop,
  output sacplru_pkg::back_stat_t stat,
  sacplru_out_if.source           out_chan
);
  import sacplru_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } back_state_t;

  back_state_t       state_r;
  back_state_t       state_nxt;
  req_t              req_r;
  logic              row_init_r;
  logic [SETS-1:0]   set_valid_r;
  cnt_t              hit_cnt_r;
  cnt_t              hit_cnt_nxt;
  cnt_t              miss_cnt_r;
  cnt_t              miss_cnt_nxt;
  logic              out_valid_r;
  logic              out_miss_r;
  way_t              out_way_r;
  cnt_t              out_hits_r;
  cnt_t              out_misses_r;

  logic [ROW_W-1:0]  rd_data;
  row_t              rd_row;
  row_t              new_row;
  logic [WAYS-1:0]   cur_valid;
  tree_t             cur_tree;
  logic              hit;
  way_t              hit_way;
  way_t              way_sel;
  logic              out_free;
  logic              do_look;

  assign q_pop    = (state_r == ST_IDLE) && q_head.valid;
  assign out_free = !out_valid_r || out_chan.ready;
  assign do_look  = (state_r == ST_LOOK) && out_free;
  assign stat.busy = (state_r == ST_LOOK);

  sacplru_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (do_look),
    .waddr (req_r.set_idx),
    .wdata (new_row),
    .re    (q_pop),
    .raddr (q_head.req.set_idx),
    .rdata (rd_data)
  );

  // untouched sets read as empty with a cleared tree
  always_comb begin
    rd_row    = row_t'(rd_data);
    cur_valid = row_init_r ? rd_row.valid : '0;
    cur_tree  = row_init_r ? rd_row.tree : '0;
  end

  // lowest matching way wins
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (cur_valid[w] && (rd_row.tag[w] == req_r.tag)) begin
        hit     = 1'b1;
        hit_way = way_t'(w);
      end
    end
  end

  always_comb begin
    way_sel              = hit ? hit_way : tree_victim(cur_tree);
    new_row.tree         = tree_touch(cur_tree, way_sel);
    new_row.valid        = cur_valid;
    new_row.valid[way_sel] = 1'b1;
    new_row.tag          = rd_row.tag;
    if (!hit) begin
      new_row.tag[way_sel] = req_r.tag;
    end
  end

  always_comb begin
    hit_cnt_nxt  = hit ? hit_cnt_r + CNT_W'(1) : hit_cnt_r;
    miss_cnt_nxt = hit ? miss_cnt_r : miss_cnt_r + CNT_W'(1);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (do_look) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      set_valid_r <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (do_look) begin
        set_valid_r[req_r.set_idx] <= 1'b1;
        hit_cnt_r                  <= hit_cnt_nxt;
        miss_cnt_r                 <= miss_cnt_nxt;
        out_valid_r                <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      req_r      <= q_head.req;
      row_init_r <= set_valid_r[q_head.req.set_idx];
    end
    if (do_look) begin
      out_miss_r   <= !hit;
      out_way_r    <= way_sel;
      out_hits_r   <= hit_cnt_nxt;
      out_misses_r <= miss_cnt_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.is_miss       = out_miss_r;
  assign out_chan.way_used      = out_way_r;
  assign out_chan.hits_so_far   = out_hits_r;
  assign out_chan.misses_so_far = out_misses_r;

endmodule

FILE: hw/rtl/set_assoc_cache_tree_plru_top.sv
// 8-way, 256-set tag cache with tree plru replacement and hit/miss counters
// the request channel takes a 64-bit byte address, the result channel returns
// hit or miss, the way used and both running counters after this request.
// a request waits in a two-entry queue in the front end; the back end reads
// the set row (tags, valid bits, tree bits) from one ram, compares all ways
// at once and writes the updated row back.
// path: a request is written into the queue, popped with its row ram read
// issued, and its result registered, given an empty queue and a free output.
// the back end takes no new request until the current row is written back,
// as its lookup fsm alternates the read and the write of the row ram.
// reset: all ways invalid and all tree bits zero at once through one flag per
// set, both counters zero; no clearing pass, requests are taken right away.
// when the receiver stalls, the result register holds, the back end waits
// with its row in hand and the queue keeps taking requests until it is full.
// depends on sacplru_pkg, sacplru_if, sacplru_front, sacplru_back
`include "set_assoc_cache_tree_plru_top_defines.svh"

module set_assoc_cache_tree_plru_top (
  input logic           clk,
  input logic           rst_n,
  sacplru_in_if.sink    in_chan,
  sacplru_out_if.source out_chan
);
  import sacplru_pkg::*;

  q_head_t    q_head;
  logic       q_pop;
  back_stat_t bstat;

  sacplru_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  sacplru_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .stat     (bstat),
    .out_chan (out_chan)
  );

  `SACPLRU_ASSERT_NOW(a_pop_needs_request, q_pop, q_head.valid, "pop from empty queue")
  `SACPLRU_ASSERT_NOW(a_full_not_empty, !in_chan.ready, q_head.valid, "queue full but empty")
  `SACPLRU_ASSERT_NEXT(a_pop_starts_lookup, q_pop, bstat.busy, "lookup not started")
  `SACPLRU_ASSERT_NOW(a_result_from_lookup, $rose(out_chan.valid), $past(bstat.busy),
                      "result without lookup")

endmodule
